// File: hdl/alt_pkg.sv
// alt_pkg: shared constants, codes and types for the array list table.
// Used by every module of the block and by its checker.
`default_nettype none

package alt_pkg;

	localparam int CAPACITY = 128;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int OP_W     = 2;
	localparam int ST_W     = 3;
	localparam int ECNT_W   = 8;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT,
		OP_REMOVE,
		OP_FIRST,
		OP_NEXT
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK,
		ST_FULL,
		ST_EMPTY,
		ST_NOT_FOUND,
		ST_END
	} st_t;

	typedef struct packed {
		logic wr;
		logic shift;
		logic cmp;
		logic cap;
		logic in_list;
		logic pick;
	} cell_ctl_t;

endpackage

`default_nettype wire

// File: hdl/alt_cell.sv
// alt_cell: one list slot; holds an entry, compares it, shifts from its upper neighbor.
// Depends on alt_pkg.
`default_nettype none

module alt_cell (
	input  wire logic                      clk,
	input  wire alt_pkg::cell_ctl_t        ctl,
	input  wire logic [alt_pkg::VAL_W-1:0] val,
	input  wire logic [alt_pkg::VAL_W-1:0] up_entry,
	output logic      [alt_pkg::VAL_W-1:0] entry,
	output logic                           match,
	output logic      [alt_pkg::VAL_W-1:0] pick_data
);

	logic [alt_pkg::VAL_W-1:0] entry_q;
	logic                      match_q;
	logic [alt_pkg::VAL_W-1:0] pdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			entry_q <= val;
		end else if (ctl.shift) begin
			entry_q <= up_entry;
		end
		if (ctl.cmp) begin
			match_q <= ctl.in_list && (entry_q == val);
		end
		if (ctl.cap) begin
			pdata_q <= ctl.pick ? entry_q : '0;
		end
	end

	assign entry     = entry_q;
	assign match     = match_q;
	assign pick_data = pdata_q;

endmodule

`default_nettype wire

// File: hdl/alt_prefix.sv
// alt_prefix: inclusive prefix OR over the cell match flags (log-depth).
// Depends on alt_pkg.
`default_nettype none

module alt_prefix (
	input  wire logic [alt_pkg::CAPACITY-1:0] m,
	output logic      [alt_pkg::CAPACITY-1:0] incl
);

	logic [alt_pkg::CAPACITY-1:0] lvl [alt_pkg::IDX_W+1];

	always_comb begin
		lvl[0] = m;
		for (int k = 0; k < alt_pkg::IDX_W; k++) begin
			lvl[k+1] = lvl[k] | (lvl[k] << (1 << k));
		end
	end

	assign incl = lvl[alt_pkg::IDX_W];

endmodule

`default_nettype wire

// File: hdl/array_list_table_core.sv
// array_list_table_core: bounded ordered list held in a row of cells, with read cursor.
// Depends on alt_pkg, alt_cell, alt_prefix.
//
//  channel | dir | handshake           | payload
//  s       | in  | s_tvalid / s_tready | s_tuser: opcode; s_tdata: value
//  m       | out | m_tvalid / m_tready | m_tuser: status; m_tdata: read_value, entry_count
//
// Each transaction passes through four steps: accept, compare in every cell, execute
// (shift/write and pick), then gather the picked entry into the output register.
// The compare and the prefix search across the cell row lie in separate steps.
// Reset (arst_n low) clears count, cursor and handshake state; entries stay undefined.
// A stalled output holds the next transaction in the gather step until it is taken.
`default_nettype none

module array_list_table_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [1:0]  s_tuser,   // [1:0] opcode
	input  wire logic [31:0] s_tdata,   // [31:0] value
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [2:0]  m_tuser,   // [2:0] status
	output logic      [39:0] m_tdata    // [31:0] read_value, [39:32] entry_count
);

	localparam int CAP = alt_pkg::CAPACITY;

	typedef enum logic [1:0] {S_IDLE, S_CMP, S_EXEC, S_RESP} state_t;

	state_t                      state_q;
	alt_pkg::op_t                op_q;
	logic [alt_pkg::VAL_W-1:0]   val_q;
	logic [alt_pkg::CNT_W-1:0]   count_q;
	logic [alt_pkg::IDX_W-1:0]   cursor_q;
	logic                        started_q;
	logic [CAP-1:0]              sel_q;
	alt_pkg::st_t                status_q;

	logic [alt_pkg::VAL_W-1:0]   entry [CAP];
	logic [alt_pkg::VAL_W-1:0]   pdata [CAP];
	logic [CAP-1:0]              match;
	logic [CAP-1:0]              incl;
	logic [CAP-1:0]              first_m;
	logic [CAP-1:0]              sel_d;
	logic [alt_pkg::IDX_W-1:0]   rd_idx;
	logic [alt_pkg::VAL_W-1:0]   rdata;

	logic          empty, full, cur_last, found, out_free, exec;
	logic          do_ins, do_rem, rd_ok, cur_zero, cur_inc;
	alt_pkg::st_t  ev_status;

	assign exec     = (state_q == S_EXEC);
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid || m_tready;
	assign empty    = (count_q == '0);
	assign full     = (count_q >= alt_pkg::CNT_W'(CAP));
	assign cur_last = (alt_pkg::CNT_W'(cursor_q) + alt_pkg::CNT_W'(1)) >= count_q;
	assign found    = |match;
	assign first_m  = match & ~(incl << 1);

	alt_prefix u_prefix (
		.m    (match),
		.incl (incl)
	);

	// read target: entry 0 for first or an unstarted cursor, else the one after it
	assign rd_idx = ((op_q == alt_pkg::OP_FIRST) || !started_q) ?
	                '0 : cursor_q + alt_pkg::IDX_W'(1);

	always_comb begin
		for (int i = 0; i < CAP; i++) begin
			sel_d[i] = (rd_idx == alt_pkg::IDX_W'(i));
		end
	end

	always_comb begin
		ev_status = alt_pkg::ST_OK;
		do_ins    = 1'b0;
		do_rem    = 1'b0;
		rd_ok     = 1'b0;
		cur_zero  = 1'b0;
		cur_inc   = 1'b0;
		case (op_q)
			alt_pkg::OP_INSERT: begin
				if (full) ev_status = alt_pkg::ST_FULL;
				else do_ins = 1'b1;
			end
			alt_pkg::OP_REMOVE: begin
				if (empty) ev_status = alt_pkg::ST_EMPTY;
				else if (!found) ev_status = alt_pkg::ST_NOT_FOUND;
				else do_rem = 1'b1;
			end
			alt_pkg::OP_FIRST: begin
				if (empty) ev_status = alt_pkg::ST_EMPTY;
				else begin
					rd_ok    = 1'b1;
					cur_zero = 1'b1;
				end
			end
			alt_pkg::OP_NEXT: begin
				if (!started_q) begin
					if (empty) ev_status = alt_pkg::ST_END;
					else begin
						rd_ok    = 1'b1;
						cur_zero = 1'b1;
					end
				end else if (cur_last) begin
					ev_status = alt_pkg::ST_END;
				end else begin
					rd_ok   = 1'b1;
					cur_inc = 1'b1;
				end
			end
			default: ev_status = alt_pkg::ST_OK;
		endcase
	end

	for (genvar i = 0; i < CAP; i++) begin : g_cell
		alt_pkg::cell_ctl_t        ctl;
		logic [alt_pkg::VAL_W-1:0] up;

		if (i == CAP - 1) begin : g_top
			assign up = '0;
		end else begin : g_mid
			assign up = entry[i+1];
		end

		assign ctl.wr      = exec && do_ins && (count_q == alt_pkg::CNT_W'(i));
		assign ctl.shift   = exec && do_rem && incl[i];
		assign ctl.cmp     = (state_q == S_CMP);
		assign ctl.cap     = exec;
		assign ctl.in_list = alt_pkg::CNT_W'(i) < count_q;
		assign ctl.pick    = (rd_ok && sel_q[i]) || (do_rem && first_m[i]);

		alt_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.val       (val_q),
			.up_entry  (up),
			.entry     (entry[i]),
			.match     (match[i]),
			.pick_data (pdata[i])
		);
	end

	always_comb begin
		rdata = '0;
		for (int i = 0; i < CAP; i++) begin
			rdata = rdata | pdata[i];
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q  <= alt_pkg::op_t'(s_tuser);
			val_q <= s_tdata;
		end
		if (state_q == S_CMP) begin
			sel_q <= sel_d;
		end
		if (exec) begin
			status_q <= ev_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			cursor_q  <= '0;
			started_q <= 1'b0;
			m_tvalid  <= 1'b0;
			m_tuser   <= '0;
			m_tdata   <= '0;
		end else begin
			if (m_tvalid && m_tready && (state_q != S_RESP)) m_tvalid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) state_q <= S_CMP;
				end
				S_CMP: state_q <= S_EXEC;
				S_EXEC: begin
					if (do_ins) count_q <= count_q + alt_pkg::CNT_W'(1);
					if (do_rem) count_q <= count_q - alt_pkg::CNT_W'(1);
					if (cur_zero) begin
						cursor_q  <= '0;
						started_q <= 1'b1;
					end
					if (cur_inc) cursor_q <= cursor_q + alt_pkg::IDX_W'(1);
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tuser  <= status_q;
						m_tdata  <= {alt_pkg::ECNT_W'(count_q), rdata};
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hdl/alt_checker.sv
// alt_checker: port-level assertions for array_list_table_core, bound to the top level.
// Depends on alt_pkg.
`default_nettype none

module alt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [2:0]  m_tuser,
	input wire logic [39:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == alt_pkg::ST_OK) || (m_tuser == alt_pkg::ST_FULL) ||
		(m_tuser == alt_pkg::ST_EMPTY) || (m_tuser == alt_pkg::ST_NOT_FOUND) ||
		(m_tuser == alt_pkg::ST_END))
		else $error("bad status code");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != alt_pkg::ST_OK) |-> m_tdata[31:0] == '0)
		else $error("data nonzero on failed transaction");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == alt_pkg::ST_FULL) |->
		m_tdata[39:32] == alt_pkg::ECNT_W'(alt_pkg::CAPACITY))
		else $error("full reported below capacity");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == alt_pkg::ST_EMPTY) |-> m_tdata[39:32] == '0)
		else $error("empty reported with entries held");

endmodule

bind array_list_table_core alt_checker u_alt_checker (.*);

`default_nettype wire
